>>> rtl/core/rle_pixel_stream_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// RLE pixel stream decoder: assertion macros
// Shared check macros; each expects clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef RLE_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH
`define RLE_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, quiet while in reset.
`define RPSD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpsd: same-cycle check failed");

// Next-cycle implication, quiet while in reset.
`define RPSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpsd: next-cycle check failed");

`endif

>>> rtl/core/rpsd_pkg.sv
// ----------------------------------------------------------------------------
// RLE pixel stream decoder package
// Shared types, register indexes, pixel format codes and the 5-bit scale table.
// ----------------------------------------------------------------------------
package rpsd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RLE_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_GRAYSCALE      = 2'd1;
    localparam logic [1:0] CFG_BITS_PER_PIXEL = 2'd2;
    localparam logic [1:0] CFG_PIXEL_COUNT    = 2'd3;

    // Pixel formats; code + 1 is the byte count of one pixel
    localparam logic [1:0] FMT_GREY = 2'd0;
    localparam logic [1:0] FMT_1555 = 2'd1;
    localparam logic [1:0] FMT_BGR  = 2'd2;
    localparam logic [1:0] FMT_BGRA = 2'd3;

    // Header byte fields
    localparam logic [7:0] HDR_REPEAT_MASK = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK  = 8'h7f;

    // c * 255 / 31, truncated, for a 5-bit channel c
    localparam logic [7:0] SCALE5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic        rle_enable;
        logic        grayscale;
        logic [7:0]  bits_per_pixel;
        logic [31:0] pixel_count;
    } cfg_t;

    // One classified result waiting for conversion
    typedef struct packed {
        logic        is_error;
        logic [1:0]  fmt;
        logic [31:0] raw;
        logic [7:0]  run;
        logic        last;
    } job_t;

endpackage

>>> rtl/core/rpsd_front.sv
// ----------------------------------------------------------------------------
// RLE pixel stream decoder: front end
// Takes one byte a cycle while the queue has room, tracks packet and pixel
// assembly, clips runs and pushes finished pixel or error jobs into the queue.
// ----------------------------------------------------------------------------
module rpsd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpsd_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                start_of_image,
    input  logic                push_ready,
    output logic                push_valid,
    output rpsd_pkg::job_t      push_job
);

    logic        in_packet_reg, in_packet_next;
    logic        repeat_reg, repeat_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [23:0] partial_reg, partial_next;
    logic [31:0] emitted_reg, emitted_next;
    logic        finished_reg, finished_next;

    logic        accept;
    logic        cur_in_packet, cur_repeat, cur_finished;
    logic [7:0]  cur_remaining;
    logic [1:0]  cur_byte_pos;
    logic [23:0] cur_partial;
    logic [31:0] cur_emitted;
    logic [1:0]  fmt;
    logic        supported;
    logic        done;
    logic [31:0] shifted;
    logic [7:0]  run;
    logic [7:0]  run_clipped;
    logic [31:0] pix_left;
    logic        clip;

    assign in_stall = !push_ready;
    assign accept   = in_valid && push_ready;

    // Start of image clears packet state before the byte is used
    assign cur_in_packet = start_of_image ? 1'b0  : in_packet_reg;
    assign cur_repeat    = start_of_image ? 1'b0  : repeat_reg;
    assign cur_remaining = start_of_image ? 8'd0  : remaining_reg;
    assign cur_byte_pos  = start_of_image ? 2'd0  : byte_pos_reg;
    assign cur_partial   = start_of_image ? 24'd0 : partial_reg;
    assign cur_emitted   = start_of_image ? 32'd0 : emitted_reg;
    assign cur_finished  = start_of_image ? 1'b0  : finished_reg;

    always_comb
    begin
        fmt       = rpsd_pkg::FMT_GREY;
        supported = 1'b0;
        priority if (cfg.grayscale)
        begin
            supported = (cfg.bits_per_pixel == 8'd8);
        end
        else if (cfg.bits_per_pixel == 8'd16)
        begin
            fmt       = rpsd_pkg::FMT_1555;
            supported = 1'b1;
        end
        else if (cfg.bits_per_pixel == 8'd24)
        begin
            fmt       = rpsd_pkg::FMT_BGR;
            supported = 1'b1;
        end
        else if (cfg.bits_per_pixel == 8'd32)
        begin
            fmt       = rpsd_pkg::FMT_BGRA;
            supported = 1'b1;
        end
        else
        begin
            supported = 1'b0;
        end
    end

    assign done    = cur_finished || (cur_emitted >= cfg.pixel_count);
    assign shifted = {24'd0, data_byte} << {cur_byte_pos, 3'b000};

    // A repeat packet stands for its whole count; anything else is one pixel
    assign run         = (cfg.rle_enable && cur_repeat) ? cur_remaining : 8'd1;
    assign pix_left    = cfg.pixel_count - cur_emitted;
    assign clip        = (pix_left[31:8] == 24'd0) && (pix_left[7:0] <= run);
    assign run_clipped = clip ? pix_left[7:0] : run;

    always_comb
    begin
        in_packet_next = in_packet_reg;
        repeat_next    = repeat_reg;
        remaining_next = remaining_reg;
        byte_pos_next  = byte_pos_reg;
        partial_next   = partial_reg;
        emitted_next   = emitted_reg;
        finished_next  = finished_reg;
        push_valid     = 1'b0;
        push_job       = '0;
        push_job.fmt   = fmt;
        push_job.raw   = {8'd0, cur_partial} | shifted;

        if (accept)
        begin
            in_packet_next = cur_in_packet;
            repeat_next    = cur_repeat;
            remaining_next = cur_remaining;
            byte_pos_next  = cur_byte_pos;
            partial_next   = cur_partial;
            emitted_next   = cur_emitted;
            finished_next  = cur_finished;

            priority if (!supported)
            begin
                push_valid        = 1'b1;
                push_job.is_error = 1'b1;
            end
            else if (done)
            begin
                // drop bytes until the next image
            end
            else if (cfg.rle_enable && !cur_in_packet)
            begin
                repeat_next    = |(data_byte & rpsd_pkg::HDR_REPEAT_MASK);
                remaining_next = (data_byte & rpsd_pkg::HDR_COUNT_MASK) + 8'd1;
                in_packet_next = 1'b1;
                byte_pos_next  = 2'd0;
                partial_next   = 24'd0;
            end
            else if (({1'b0, cur_byte_pos} + 3'd1) < ({1'b0, fmt} + 3'd1))
            begin
                partial_next  = cur_partial | shifted[23:0];
                byte_pos_next = cur_byte_pos + 2'd1;
            end
            else
            begin
                byte_pos_next = 2'd0;
                partial_next  = 24'd0;
                if (cfg.rle_enable)
                begin
                    if (cur_repeat)
                    begin
                        in_packet_next = 1'b0;
                        remaining_next = 8'd0;
                    end
                    else
                    begin
                        remaining_next = cur_remaining - 8'd1;
                        if (remaining_next == 8'd0)
                        begin
                            in_packet_next = 1'b0;
                        end
                    end
                end
                emitted_next  = cur_emitted + {24'd0, run_clipped};
                finished_next = clip;
                push_valid    = 1'b1;
                push_job.run  = run_clipped;
                push_job.last = clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            repeat_reg    <= 1'b0;
            remaining_reg <= 8'd0;
            byte_pos_reg  <= 2'd0;
            partial_reg   <= 24'd0;
            emitted_reg   <= 32'd0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            repeat_reg    <= repeat_next;
            remaining_reg <= remaining_next;
            byte_pos_reg  <= byte_pos_next;
            partial_reg   <= partial_next;
            emitted_reg   <= emitted_next;
            finished_reg  <= finished_next;
        end
    end

endmodule

>>> rtl/core/rpsd_queue.sv
// ----------------------------------------------------------------------------
// RLE pixel stream decoder: job queue
// Small FIFO that parts the front end from the back end.
// ----------------------------------------------------------------------------
`include "rle_pixel_stream_decoder_core_defines.svh"

module rpsd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  rpsd_pkg::job_t      push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rpsd_pkg::job_t      head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rpsd_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push_valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RPSD_ASSERT(a_no_push_when_full, full, !push_valid)
    `RPSD_ASSERT(a_no_pop_when_empty, pop, head_valid)
    `RPSD_ASSERT_NEXT(a_full_holds, full && !pop, full)

endmodule

>>> rtl/core/rpsd_back.sv
// ----------------------------------------------------------------------------
// RLE pixel stream decoder: back end
// Pops jobs, converts the raw pixel to ARGB8888 and holds the result word.
// ----------------------------------------------------------------------------
module rpsd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  rpsd_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         pixel_argb,
    output logic [7:0]          run_length,
    output logic                last_run,
    output logic                status
);

    logic        out_valid_reg;
    logic [31:0] argb_reg, argb_next;
    logic [7:0]  run_reg, run_next;
    logic        last_reg, last_next;
    logic        status_reg, status_next;
    logic [31:0] converted;

    // Load when the output slot is empty or being taken this cycle
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (head_job.fmt)
            rpsd_pkg::FMT_GREY:
                converted = {8'hff, head_job.raw[7:0], head_job.raw[7:0], head_job.raw[7:0]};
            rpsd_pkg::FMT_1555:
                converted = {{8{head_job.raw[15]}},
                             rpsd_pkg::SCALE5_LUT[head_job.raw[14:10]],
                             rpsd_pkg::SCALE5_LUT[head_job.raw[9:5]],
                             rpsd_pkg::SCALE5_LUT[head_job.raw[4:0]]};
            rpsd_pkg::FMT_BGR:
                converted = {8'hff, head_job.raw[23:0]};
            rpsd_pkg::FMT_BGRA:
                converted = head_job.raw;
            default:
                converted = head_job.raw;
        endcase

        if (head_job.is_error)
        begin
            argb_next   = 32'd0;
            run_next    = 8'd0;
            last_next   = 1'b0;
            status_next = 1'b1;
        end
        else
        begin
            argb_next   = converted;
            run_next    = head_job.run;
            last_next   = head_job.last;
            status_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            argb_reg   <= argb_next;
            run_reg    <= run_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_argb = argb_reg;
    assign run_length = run_reg;
    assign last_run   = last_reg;
    assign status     = status_reg;

endmodule

>>> rtl/core/rle_pixel_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// RLE pixel stream decoder core
// Decodes raw or run-length coded Targa pixel data into ARGB8888 runs.
// ----------------------------------------------------------------------------
// The core takes one data byte per clock while in_stall is low and gives at
// most one result word per byte: a pixel in ARGB8888 with its run count, or an
// error word when the configured depth is not supported. A byte is taken at a
// rising edge with in_valid high and in_stall low; its result, if any, shows on
// the output just after the next rising edge at the earliest. The rate is one
// byte per cycle while the queue has room, set by the front end's packet and
// pixel update, whose longest path is the 32-bit subtract and compare that
// clips a run at the pixel total. Results wait in a QUEUE_DEPTH-entry job
// queue and then an output register, so the input keeps flowing while the
// consumer holds out_stall; in_stall rises only once the queue is full. Write
// configuration only while the core is idle. With a supported depth, header
// bytes, partial pixels and bytes after the image is complete give no word;
// start_of_image clears the image state before its own byte is used.
// ----------------------------------------------------------------------------
`include "rle_pixel_stream_decoder_core_defines.svh"

module rle_pixel_stream_decoder_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_image,

    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_argb,
    output logic [7:0]  run_length,
    output logic        last_run,
    output logic        status
);

    rpsd_pkg::cfg_t cfg_reg;
    rpsd_pkg::job_t push_job;
    rpsd_pkg::job_t head_job;
    logic           push_valid;
    logic           queue_full;
    logic           head_valid;
    logic           pop;

    // Configuration registers; all but the pixel count keep only the low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rle_enable     <= 1'b0;
            cfg_reg.grayscale      <= 1'b0;
            cfg_reg.bits_per_pixel <= 8'd32;
            cfg_reg.pixel_count    <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rpsd_pkg::CFG_RLE_ENABLE:     cfg_reg.rle_enable     <= cfg_data[0];
                rpsd_pkg::CFG_GRAYSCALE:      cfg_reg.grayscale      <= cfg_data[0];
                rpsd_pkg::CFG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg_data[7:0];
                rpsd_pkg::CFG_PIXEL_COUNT:    cfg_reg.pixel_count    <= cfg_data;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: classify each byte and advance packet and pixel state
    rpsd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .push_ready     (!queue_full),
        .push_valid     (push_valid),
        .push_job       (push_job)
    );

    // Queue: hold finished jobs so either side can stall alone
    rpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: convert to ARGB and register the result word
    rpsd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_argb (pixel_argb),
        .run_length (run_length),
        .last_run   (last_run),
        .status     (status)
    );

    `RPSD_ASSERT(a_error_word_clean, out_valid && status,
        (pixel_argb == 32'd0) && (run_length == 8'd0) && !last_run)
    `RPSD_ASSERT(a_stall_tracks_queue, in_stall, queue_full)
    `RPSD_ASSERT_NEXT(a_out_held, out_valid && out_stall,
        out_valid && $stable(pixel_argb) && $stable(run_length) && $stable(status))

endmodule
